// ----- rtl/core/dhbp_pkg.sv -----
package dhbp_pkg;

    // Header field tags carried on the result channel
    typedef enum logic [4:0] {
        C_VER     = 5'd0,
        C_HLEN    = 5'd1,
        C_FLAGS   = 5'd2,
        C_ERR     = 5'd3,
        C_DEST    = 5'd4,
        C_SRC     = 5'd5,
        C_SEQ     = 5'd6,
        C_ACK     = 5'd7,
        C_MSS     = 5'd8,
        C_OPTNUM  = 5'd9,
        C_OPTLEN  = 5'd10,
        C_OPT1    = 5'd11,
        C_OPT2    = 5'd12,
        C_FRAG    = 5'd13,
        C_FRAGTOT = 5'd14,
        C_BODY    = 5'd15,
        C_TEXT    = 5'd16,
        C_UNP     = 5'd17
    } t_field;

    // Flag byte bits
    localparam int FL_SYN_BIT  = 1;
    localparam int FL_ACK_BIT  = 2;
    localparam int FL_BCST_BIT = 4;

    localparam logic [7:0] GOOD_VERSION = 8'd2;
    localparam logic [7:0] HDR_UNIT     = 8'd4;
    localparam int         PKT_LEN_W    = 16;

    // One result transaction
    typedef struct packed {
        logic [7:0]  byte_echo;
        t_field      field_code;
        logic [31:0] field_value;
        logic        field_end;
        logic        header_malformed;
        logic        bad_option;
    } t_result;

    // Remaining bytes after the first one of a field
    function automatic logic [2:0] field_extra(input t_field f);
        case (f)
            C_DEST, C_SRC, C_SEQ, C_ACK, C_MSS:    field_extra = 3'd3;
            C_OPT1, C_OPT2, C_FRAG, C_FRAGTOT:     field_extra = 3'd1;
            default:                               field_extra = 3'd0;
        endcase
    endfunction

endpackage

// ----- rtl/core/delivery_header_byte_parser_unit.sv -----
// Each accepted input transaction is tagged and its result registered.
// One byte per cycle while o_in_stall is low; the per-byte tagging is one level of logic
// between the tracking state and the result register.
// A skid register behind the result register absorbs one transaction when the
// output stalls; o_in_stall is that skid register's full flag.
// Reset (i_rst_n low, synchronous) clears all parser state and both result valid flags.
module delivery_header_byte_parser_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_first_of_packet,
    input  logic [dhbp_pkg::PKT_LEN_W-1:0] i_packet_length,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_byte_echo,
    output logic [4:0]                    o_field_code,
    output logic [31:0]                   o_field_value,
    output logic                          o_field_end,
    output logic                          o_header_malformed,
    output logic                          o_bad_option
);
    import dhbp_pkg::*;

    localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

    // Parser state
    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [7:0]  r_hdr, n_hdr;
    logic [7:0]  r_flags, n_flags;
    logic        r_body, n_body;
    logic        r_v2, n_v2;
    t_field      r_cur, n_cur;
    logic [2:0]  r_left, n_left;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_optnum, n_optnum;
    logic        r_badopt, n_badopt;
    logic        r_malf, n_malf;
    logic        r_open, n_open;

    // Result slots
    t_result     r_out, r_skd, n_res;
    logic        r_out_valid, r_skd_valid;

    logic        w_in_acc, w_out_pop;
    logic [LENGTH_BITS+PKT_LEN_W-1:0] w_len_ext;
    logic [7:0]  w_limit;
    logic        w_opt_more;
    t_field      w_after_opt, w_next;
    logic        w_syn, w_ack, w_bcst;

    assign w_in_acc   = i_in_valid && !r_skd_valid;
    assign w_out_pop  = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skd_valid;
    assign w_len_ext  = {{LENGTH_BITS{1'b0}}, i_packet_length};

    assign w_syn  = r_flags[FL_SYN_BIT];
    assign w_ack  = r_flags[FL_ACK_BIT];
    assign w_bcst = r_flags[FL_BCST_BIT];

    // Option loop: start another option while below the header limit
    assign w_limit     = r_body ? (r_hdr - HDR_UNIT) : r_hdr;
    assign w_opt_more  = r_pos < LENGTH_BITS'(w_limit);
    assign w_after_opt = w_opt_more ? C_OPTNUM : (r_body ? C_FRAG : C_UNP);

    // Field that follows the current one, ordered by the flag byte
    always_comb begin
        case (r_cur)
            C_ERR: begin
                if (r_hdr <= HDR_UNIT)     w_next = C_UNP;
                else if (w_ack)            w_next = C_DEST;
                else if (w_syn || w_bcst)  w_next = C_SRC;
                else                       w_next = C_SEQ;
            end
            C_DEST: begin
                if (w_syn || w_bcst) w_next = C_SRC;
                else                 w_next = C_SEQ;
            end
            C_SRC: w_next = C_SEQ;
            C_SEQ: begin
                if (w_ack)      w_next = C_ACK;
                else if (w_syn) w_next = C_MSS;
                else            w_next = w_after_opt;
            end
            C_ACK: begin
                if (w_syn) w_next = C_MSS;
                else       w_next = w_after_opt;
            end
            C_OPTNUM: begin
                if (r_optnum != 8'd0) w_next = C_OPTLEN;
                else                  w_next = w_after_opt;
            end
            C_OPTLEN: begin
                if (r_optnum == 8'd1)      w_next = C_OPT1;
                else if (r_optnum == 8'd2) w_next = C_OPT2;
                else                       w_next = w_after_opt;
            end
            C_MSS, C_OPT1, C_OPT2:  w_next = w_after_opt;
            C_FRAG:                 w_next = C_FRAGTOT;
            C_FRAGTOT, C_BODY:      w_next = C_BODY;
            default:                w_next = C_UNP;
        endcase
    end

    // Per-byte tagging and state update
    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_hdr    = r_hdr;
        n_flags  = r_flags;
        n_body   = r_body;
        n_v2     = r_v2;
        n_cur    = r_cur;
        n_left   = r_left;
        n_acc    = r_acc;
        n_optnum = r_optnum;
        n_badopt = r_badopt;
        n_malf   = r_malf;
        n_open   = r_open;

        n_res.byte_echo        = i_data_byte;
        n_res.field_code       = C_UNP;
        n_res.field_value      = {24'd0, i_data_byte};
        n_res.field_end        = 1'b1;
        n_res.header_malformed = 1'b0;
        n_res.bad_option       = 1'b0;

        if (i_first_of_packet || r_open) begin
            if (i_first_of_packet) begin
                // New packet: clear everything, then take the version byte
                n_pos    = '0;
                n_hdr    = '0;
                n_flags  = '0;
                n_body   = 1'b0;
                n_left   = '0;
                n_acc    = '0;
                n_optnum = '0;
                n_badopt = 1'b0;
                n_malf   = 1'b0;
                n_open   = 1'b1;
                n_len    = w_len_ext[LENGTH_BITS-1:0];
                n_v2     = (i_data_byte == GOOD_VERSION);
                n_res.field_code = C_VER;
            end else if (!r_v2) begin
                n_res.field_code = C_TEXT;
            end else if (r_pos == LENGTH_BITS'(1)) begin
                n_hdr  = {i_data_byte[5:0], 2'b00};
                n_malf = LENGTH_BITS'(n_hdr) > r_len;
                n_body = r_len > LENGTH_BITS'(n_hdr);
                n_res.field_code = C_HLEN;
            end else if (r_pos == LENGTH_BITS'(2)) begin
                n_flags = i_data_byte;
                n_res.field_code = C_FLAGS;
            end else if (r_pos == LENGTH_BITS'(3)) begin
                n_res.field_code = C_ERR;
            end else if (r_left != 3'd0) begin
                // Continue a multi-byte field
                n_acc  = {r_acc[23:0], i_data_byte};
                n_left = r_left - 3'd1;
                n_res.field_code  = r_cur;
                n_res.field_value = n_acc;
                n_res.field_end   = (n_left == 3'd0);
            end else begin
                // Start the next field
                n_acc  = {24'd0, i_data_byte};
                n_left = field_extra(w_next);
                n_res.field_code = w_next;
                n_res.field_end  = (n_left == 3'd0);
                if (w_next == C_OPTNUM) begin
                    n_optnum = i_data_byte;
                    if (i_data_byte > 8'd2) begin
                        n_badopt = 1'b1;
                        n_body   = 1'b0;
                    end
                end
            end
            n_cur = n_res.field_code;
            if (n_pos != POS_MAX) n_pos = n_pos + LENGTH_BITS'(1);
            n_res.header_malformed = n_malf;
            n_res.bad_option       = n_badopt;
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_hdr    <= '0;
            r_flags  <= '0;
            r_body   <= 1'b0;
            r_v2     <= 1'b0;
            r_cur    <= C_VER;
            r_left   <= '0;
            r_acc    <= '0;
            r_optnum <= '0;
            r_badopt <= 1'b0;
            r_malf   <= 1'b0;
            r_open   <= 1'b0;
        end else if (w_in_acc) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_hdr    <= n_hdr;
            r_flags  <= n_flags;
            r_body   <= n_body;
            r_v2     <= n_v2;
            r_cur    <= n_cur;
            r_left   <= n_left;
            r_acc    <= n_acc;
            r_optnum <= n_optnum;
            r_badopt <= n_badopt;
            r_malf   <= n_malf;
            r_open   <= n_open;
        end
    end

    // Result register and skid register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (w_out_pop) begin
            if (r_skd_valid) begin
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_acc;
            end
        end else if (w_in_acc) begin
            if (r_out_valid) r_skd_valid <= 1'b1;
            else             r_out_valid <= 1'b1;
        end
    end

    // Result payloads
    always_ff @(posedge i_clk) begin
        if (w_out_pop) begin
            if (r_skd_valid) r_out <= r_skd;
            else if (w_in_acc) r_out <= n_res;
        end else if (w_in_acc) begin
            if (r_out_valid) r_skd <= n_res;
            else             r_out <= n_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_byte_echo        = r_out.byte_echo;
    assign o_field_code       = r_out.field_code;
    assign o_field_value      = r_out.field_value;
    assign o_field_end        = r_out.field_end;
    assign o_header_malformed = r_out.header_malformed;
    assign o_bad_option       = r_out.bad_option;

endmodule

// ----- rtl/core/dhbp_checker.sv -----
module dhbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_byte_echo,
    input logic [4:0]  o_field_code,
    input logic [31:0] o_field_value,
    input logic        o_field_end
    ,input logic       o_header_malformed
    ,input logic       o_bad_option
);
    import dhbp_pkg::*;

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_echo)
            && $stable(o_field_code) && $stable(o_field_value))
        else $error("stalled result changed");

    // Input side only stalls while a result is waiting
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    // Skid slot fills only after a stalled output saw another transaction
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall && i_in_valid))
        else $error("input stall without output backpressure");

    // Single-byte tags always close their field
    a_single_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_field_code == C_VER || o_field_code == C_BODY
            || o_field_code == C_TEXT || o_field_code == C_UNP) |-> o_field_end)
        else $error("single-byte field without end mark");

    // Packet flags start clear on the version byte
    a_ver_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_field_code == C_VER |-> !o_header_malformed && !o_bad_option)
        else $error("packet flags set on version byte");

endmodule

bind delivery_header_byte_parser_unit dhbp_checker u_dhbp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_byte_echo        (o_byte_echo),
    .o_field_code       (o_field_code),
    .o_field_value      (o_field_value),
    .o_field_end        (o_field_end),
    .o_header_malformed (o_header_malformed),
    .o_bad_option       (o_bad_option)
);

// ----- sim/tb_delivery_header_byte_parser_unit.sv -----
`timescale 1ns / 100ps

module tb_delivery_header_byte_parser_unit;
    import dhbp_pkg::*;

    // Parser tracking state mirrored by the predictor
    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  hdr_len;
        logic [7:0]  flags;
        logic        body;
        logic        v2;
        t_field      cur;
        logic [2:0]  left;
        logic [31:0] acc;
        logic [7:0]  opt_num;
        logic        bad_opt;
        logic        malformed;
        logic [15:0] pkt_len;
        logic        open;
    } t_hdr_track;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_first_of_packet = 1'b0;
    logic [PKT_LEN_W-1:0] i_packet_length = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_byte_echo;
    logic [4:0]  o_field_code;
    logic [31:0] o_field_value;
    logic        o_field_end;
    logic        o_header_malformed;
    logic        o_bad_option;

    t_hdr_track  track = '0;
    t_result     tag_q[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          hold_len = 0;
    bit          quiet = 1'b0;

    delivery_header_byte_parser_unit #(.LENGTH_BITS(16)) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_first_of_packet  (i_first_of_packet),
        .i_packet_length    (i_packet_length),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_byte_echo        (o_byte_echo),
        .o_field_code       (o_field_code),
        .o_field_value      (o_field_value),
        .o_field_end        (o_field_end),
        .o_header_malformed (o_header_malformed),
        .o_bad_option       (o_bad_option)
    );

    always #1 i_clk = ~i_clk;

    // Run limit
    initial begin
        #2000000;
        $display("** delivery_header_byte_parser_unit: FAILED **");
        $finish;
    end

    // Cycles of idling before the next transaction on either side
    function automatic int idle_cycles();
        if (quiet) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Bytes that follow the first byte of a field
    function automatic logic [2:0] extra_bytes(input t_field f);
        case (f)
            C_DEST, C_SRC, C_SEQ, C_ACK, C_MSS: return 3'd3;
            C_OPT1, C_OPT2, C_FRAG, C_FRAGTOT:  return 3'd1;
            default:                            return 3'd0;
        endcase
    endfunction

    // Option loop: another option, or fragment / unparsed once past the limit
    function automatic t_field after_options(input t_hdr_track st);
        int limit;
        limit = st.body ? int'(st.hdr_len) - int'(HDR_UNIT) : int'(st.hdr_len);
        if (int'(st.pos) < limit) return C_OPTNUM;
        return st.body ? C_FRAG : C_UNP;
    endfunction

    // Field that follows the one just finished, given the flag byte
    function automatic t_field next_tag(input t_hdr_track st);
        t_field f;
        f = st.cur;
        if (f == C_ERR) begin
            if (st.hdr_len <= HDR_UNIT) return C_UNP;
            if (st.flags[FL_ACK_BIT]) return C_DEST;
            f = C_DEST;
        end
        if (f == C_DEST) begin
            if (st.flags[FL_SYN_BIT] || st.flags[FL_BCST_BIT]) return C_SRC;
            f = C_SRC;
        end
        if (f == C_SRC) return C_SEQ;
        if (f == C_SEQ) begin
            if (st.flags[FL_ACK_BIT]) return C_ACK;
            f = C_ACK;
        end
        if (f == C_ACK) begin
            if (st.flags[FL_SYN_BIT]) return C_MSS;
            f = C_MSS;
        end
        if (f == C_OPTNUM && st.opt_num > 8'd0) return C_OPTLEN;
        if (f == C_OPTLEN && st.opt_num == 8'd1) return C_OPT1;
        if (f == C_OPTLEN && st.opt_num == 8'd2) return C_OPT2;
        if (f inside {C_MSS, C_OPTNUM, C_OPTLEN, C_OPT1, C_OPT2}) return after_options(st);
        if (f == C_FRAG) return C_FRAGTOT;
        if (f == C_FRAGTOT || f == C_BODY) return C_BODY;
        return C_UNP;
    endfunction

    // Tag one byte and advance the tracking state
    function automatic t_result tag_byte(inout t_hdr_track st, input logic [7:0] b,
                                         input logic first, input logic [15:0] plen);
        t_result r;
        t_field  code;
        logic [31:0] val;
        logic    fend;
        fend = 1'b1;
        val  = {24'h0, b};
        if (first) begin
            st         = '0;
            st.open    = 1'b1;
            st.pkt_len = plen;
            st.v2      = (b == GOOD_VERSION);
            code       = C_VER;
        end else if (!st.open) begin
            // no packet opened since reset: unparsed, state untouched
            r.byte_echo        = b;
            r.field_code       = C_UNP;
            r.field_value      = val;
            r.field_end        = 1'b1;
            r.header_malformed = 1'b0;
            r.bad_option       = 1'b0;
            return r;
        end else if (!st.v2) begin
            code = C_TEXT;
        end else if (st.pos == 16'd1) begin
            st.hdr_len   = {b[5:0], 2'b00};
            st.malformed = {8'h0, st.hdr_len} > st.pkt_len;
            st.body      = st.pkt_len > {8'h0, st.hdr_len};
            code         = C_HLEN;
        end else if (st.pos == 16'd2) begin
            st.flags = b;
            code     = C_FLAGS;
        end else if (st.pos == 16'd3) begin
            code = C_ERR;
        end else if (st.left > 3'd0) begin
            code    = st.cur;
            st.acc  = {st.acc[23:0], b};
            val     = st.acc;
            st.left = st.left - 3'd1;
            fend    = (st.left == 3'd0);
        end else begin
            code    = next_tag(st);
            st.acc  = val;
            st.left = extra_bytes(code);
            fend    = (st.left == 3'd0);
            if (code == C_OPTNUM) begin
                st.opt_num = b;
                if (b > 8'd2) begin
                    st.bad_opt = 1'b1;
                    st.body    = 1'b0;
                end
            end
        end
        st.cur = code;
        if (st.pos != 16'hFFFF) st.pos = st.pos + 16'd1;
        r.byte_echo        = b;
        r.field_code       = code;
        r.field_value      = val;
        r.field_end        = fend;
        r.header_malformed = st.malformed;
        r.bad_option       = st.bad_opt;
        return r;
    endfunction

    // Send one byte transaction, then record its expected tag
    task automatic send_byte(input logic [7:0] d, input logic f, input logic [15:0] l);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_data_byte       <= d;
        i_first_of_packet <= f;
        i_packet_length   <= l;
        do @(posedge i_clk); while (o_in_stall);
        tag_q.push_back(tag_byte(track, d, f, l));
        bytes_sent++;
    endtask

    // Stop offering and wait until every expected tag is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tag_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiver: random stall per transaction, or one long hold-off on request
    initial begin : rx_side
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else begin
                n = idle_cycles();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : chk
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tag_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte 0x%0h code %0d",
                         $time, o_byte_echo, o_field_code);
                mismatch_count++;
            end else begin
                want = tag_q.pop_front();
                compare_field("byte_echo", 32'(want.byte_echo), 32'(o_byte_echo));
                compare_field("field_code", 32'(want.field_code), 32'(o_field_code));
                compare_field("field_value", want.field_value, o_field_value);
                compare_field("field_end", 32'(want.field_end), 32'(o_field_end));
                compare_field("header_malformed", 32'(want.header_malformed),
                              32'(o_header_malformed));
                compare_field("bad_option", 32'(want.bad_option), 32'(o_bad_option));
            end
        end
    end

    // Bytes before any packet has been opened
    task automatic test_unopened_bytes();
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        drain_results();
    endtask

    // Version other than two: text body
    task automatic test_text_packet();
        send_byte(8'hFF, 1'b1, 16'hFFFF);
        send_byte(8'h00, 1'b0, 16'h0000);
        drain_results();
    endtask

    // Short header, longer than a zero-length packet
    task automatic test_short_header();
        send_byte(GOOD_VERSION, 1'b1, 16'h0000);
        send_byte(8'h01, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'h0000);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'hAA, 1'b0, 16'h0000);
        drain_results();
    endtask

    // Full path: seq, pad, one option, fragment, fragment total, body
    task automatic test_option_packet();
        logic [7:0] bytes_in [0:17];
        int i;
        bytes_in = '{GOOD_VERSION, 8'h04, 8'h00, 8'h5A, 8'h12, 8'h34, 8'h56, 8'h78,
                     8'h00, 8'h01, 8'h02, 8'hBE, 8'hEF, 8'h00, 8'h01, 8'h00, 8'h02, 8'hC3};
        send_byte(bytes_in[0], 1'b1, 16'd20);
        for (i = 1; i < 18; i++) send_byte(bytes_in[i], 1'b0, 16'd20);
        drain_results();
    endtask

    // One packet of random shape; option-number bytes drawn from a mix
    task automatic send_random_packet();
        t_hdr_track probe;
        t_result    look;
        logic [7:0] ver, hb, b;
        logic [7:0] hl;
        int sel, p, plen, n, i;
        sel = $urandom_range(0, 99);
        p   = $urandom_range(0, 99);
        if (sel < 15 || p < 10) hb = 8'($urandom_range(0, 255));
        else if (p < 25)        hb = 8'($urandom_range(0, 1));
        else                    hb = 8'($urandom_range(2, 12));
        hl = {hb[5:0], 2'b00};
        ver = GOOD_VERSION;
        if (sel < 10) begin
            ver = 8'($urandom_range(0, 255));
            if (ver == GOOD_VERSION) ver = 8'hFF;
        end
        p = $urandom_range(0, 99);
        if (p < 55)      plen = int'(hl) + $urandom_range(1, 10);
        else if (p < 70) plen = int'(hl);
        else if (p < 88) plen = int'(hl) - $urandom_range(1, 4);
        else             plen = $urandom_range(0, 65535);
        plen = plen & 16'hFFFF;
        if (plen <= 48) n = plen + $urandom_range(0, 3);
        else            n = $urandom_range(4, 48);
        if (n < 1) n = 1;
        send_byte(ver, 1'b1, plen[15:0]);
        for (i = 1; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i == 1) b = hb;
            probe = track;
            look  = tag_byte(probe, b, 1'b0, 16'h0000);
            // well-formed packets mostly carry pad, option 1 or option 2
            if (sel >= 15 && look.field_code == C_OPTNUM) begin
                p = $urandom_range(0, 99);
                if (p < 90) b = 8'(p % 3);
                else        b = 8'($urandom_range(3, 255));
            end
            send_byte(b, 1'b0, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_random_packets();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 1600) begin
            quiet = ($urandom_range(0, 4) == 0);
            send_random_packet();
        end
        quiet = 1'b0;
        drain_results();
    endtask

    // Receiver holds off for a long stretch while bytes keep coming
    task automatic test_output_backpressure();
        quiet    = 1'b1;
        hold_len = 64;
        send_byte(GOOD_VERSION, 1'b1, 16'hFFFF);
        send_byte(8'h03, 1'b0, 16'h0000);
        repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b0,
                              16'($urandom_range(0, 65535)));
        quiet = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unopened_bytes();
        test_text_packet();
        test_short_header();
        test_option_packet();
        test_output_backpressure();
        test_random_packets();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** delivery_header_byte_parser_unit: PASSED **");
        end else begin
            $display("** delivery_header_byte_parser_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- delivery_header_byte_parser_unit.f -----
rtl/core/dhbp_pkg.sv
rtl/core/delivery_header_byte_parser_unit.sv
rtl/core/dhbp_checker.sv
sim/tb_delivery_header_byte_parser_unit.sv
